FILE: hdl/wavetable_interpolator_unit_assert.svh
// Assertion macros for the wavetable interpolator
`ifndef WAVETABLE_INTERPOLATOR_UNIT_ASSERT_SVH
`define WAVETABLE_INTERPOLATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define WIU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define WIU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/wiu_pkg.sv
`default_nettype none
package wiu_pkg;

    localparam int TABLE_DEPTH     = 1024;
    localparam int SAMPLE_BITS     = 16;
    localparam int PHASE_FRAC_BITS = 16;
    localparam int PHASE_BITS      = 24;
    localparam int COS_ENTRIES     = 256;
    localparam int COS_Q           = 15;
    localparam int POLY_Q          = 30;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int SIZE_W = 11;
    localparam int MODE_W = 2;
    localparam int CIDX_W = $clog2(COS_ENTRIES + 1);
    localparam int TDATA_IN_W  = 56;
    localparam int TDATA_OUT_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_STEP   = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_COSINE = 2'd2,
        MODE_ZERO   = 2'd3
    } interp_mode_t;

    typedef enum logic {
        ITEM_WRITE  = 1'b0,
        ITEM_LOOKUP = 1'b1
    } item_kind_t;

    typedef enum logic {
        REG_INTERP_MODE = 1'b0,
        REG_TABLE_SIZE  = 1'b1
    } reg_index_t;

    typedef logic [15:0] cos_rom_t [COS_ENTRIES+1];

    localparam longint COS_COEF [6] = '{
        64'sd1324675879, 64'sd272375558, 64'sd22401994,
        64'sd987048, 64'sd27060, 64'sd506
    };

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        longint   u;
        longint   u2;
        longint   s;
        longint   res;
        int       k;
        int       i;
        for (k = 0; k <= COS_ENTRIES; k++)
        begin
            u  = (longint'(k) <<< POLY_Q) / COS_ENTRIES;
            u2 = (u * u) >>> POLY_Q;
            s  = COS_COEF[5];
            for (i = 4; i >= 0; i--)
            begin
                s = COS_COEF[i] - ((s * u2) >>> POLY_Q);
            end
            res = (longint'(1) <<< POLY_Q) - ((s * u2) >>> POLY_Q);
            if (res < 0)
            begin
                res = 0;
            end
            else
            begin
                res = (res * 32767 + (longint'(1) <<< (POLY_Q - 1))) >>> POLY_Q;
                if (res > 32767)
                begin
                    res = 32767;
                end
            end
            rom[k] = res[15:0];
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage
`default_nettype wire

FILE: hdl/wiu_ram.sv
`default_nettype none
module wiu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata0,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/wavetable_interpolator_unit.sv
// Wavetable interpolator. Write items (tuser 0) load one Q1.15 sample into a
// 1024-entry table; lookup items (tuser 1) take a Q8.16 phase and return one
// Q1.15 sample by step, linear or cosine interpolation between two adjacent
// entries, chosen by the interp_mode register, over table_size entries, or zero
// in the zero mode. One item is accepted every cycle while the output is not
// stalled. The phase multiply is registered at acceptance, then the two-port
// table read, the weighting multiply and the final sum take one stage each.
// A stalled output holds the whole pipeline. Write items give no result.
// An entry must be written before any lookup reads it.
`default_nettype none
module wavetable_interpolator_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // write_index[9:0], write_sample[25:10], phase[49:26], zero fill
    input  wire logic [wiu_pkg::TDATA_IN_W-1:0]   s_tdata,
    // item kind: 0 write, 1 lookup
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // sample_out[15:0]
    output logic      [wiu_pkg::TDATA_OUT_W-1:0]  m_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [2:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready
);
    import wiu_pkg::*;

    `include "wavetable_interpolator_unit_assert.svh"

    localparam int PROD_W = PHASE_FRAC_BITS + SIZE_W;
    localparam int CPROD_W = PHASE_FRAC_BITS + 1 + CIDX_W;
    localparam logic [PHASE_FRAC_BITS:0] FULL = (PHASE_FRAC_BITS+1)'(1) << PHASE_FRAC_BITS;
    localparam logic [PHASE_FRAC_BITS-1:0] HALF =
        PHASE_FRAC_BITS'(1) << (PHASE_FRAC_BITS - 1);

    interp_mode_t      mode_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_eff;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LINEAR;
            size_reg <= SIZE_W'(TABLE_DEPTH);
        end
        else if (cfg_wr)
        begin
            unique case (reg_index_t'(paddr[2]))
                REG_INTERP_MODE: mode_reg <= interp_mode_t'(pwdata[MODE_W-1:0]);
                REG_TABLE_SIZE:  size_reg <= pwdata[SIZE_W-1:0];
                default:         mode_reg <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index_t'(paddr[2]))
            REG_INTERP_MODE: prdata = {(32-MODE_W)'(0), mode_reg};
            REG_TABLE_SIZE:  prdata = {(32-SIZE_W)'(0), size_reg};
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        if (size_reg == '0)
            size_eff = SIZE_W'(1);
        else if (size_reg > SIZE_W'(TABLE_DEPTH))
            size_eff = SIZE_W'(TABLE_DEPTH);
        else
            size_eff = size_reg;
    end

    logic advance;
    logic out_v_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    assign advance  = !out_v_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

    // stage 1: phase fraction times size
    logic                   v1_reg;
    logic                   lk1_reg;
    logic [PROD_W-1:0]      prod1_reg;
    logic [IDX_W-1:0]       widx1_reg;
    logic [SAMPLE_BITS-1:0] wsamp1_reg;
    logic [PHASE_FRAC_BITS-1:0] in_frac;

    assign in_frac = s_tdata[26 +: PHASE_FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (advance)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lk1_reg    <= (item_kind_t'(s_tuser) == ITEM_LOOKUP);
            prod1_reg  <= PROD_W'(in_frac) * PROD_W'(size_eff);
            widx1_reg  <= s_tdata[IDX_W-1:0];
            wsamp1_reg <= s_tdata[10 +: SAMPLE_BITS];
        end
    end

    // stage 2: entry indices, table access, cosine lookup
    logic [SIZE_W-1:0]          i1;
    logic [SIZE_W-1:0]          i1p;
    logic [SIZE_W-1:0]          i2;
    logic [PHASE_FRAC_BITS-1:0] r1;
    logic [PHASE_FRAC_BITS:0]   cos_arg;
    logic [CPROD_W-1:0]         cprod;
    logic [CIDX_W-1:0]          cidx;
    logic signed [16:0]         cval;
    logic [SAMPLE_BITS-1:0]     rd1;
    logic [SAMPLE_BITS-1:0]     rd2;

    assign i1  = prod1_reg[PHASE_FRAC_BITS +: SIZE_W];
    assign i1p = i1 + SIZE_W'(1);
    assign i2  = (i1p == size_eff) ? '0 : i1p;
    assign r1  = prod1_reg[PHASE_FRAC_BITS-1:0];

    always_comb
    begin
        cos_arg = (r1 < HALF) ? {1'b0, r1} : (FULL - {1'b0, r1});
        cprod   = CPROD_W'(cos_arg) * CPROD_W'(COS_ENTRIES);
        cidx    = CIDX_W'(cprod >> (PHASE_FRAC_BITS - 1));
        if (r1 < HALF)
            cval = $signed({1'b0, COS_ROM[cidx]});
        else
            cval = -$signed({1'b0, COS_ROM[cidx]});
    end

    wiu_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk    (clk),
        .we     (advance && v1_reg && !lk1_reg),
        .waddr  (widx1_reg),
        .wdata  (wsamp1_reg),
        .re     (advance),
        .raddr0 (i1[IDX_W-1:0]),
        .raddr1 (i2[IDX_W-1:0]),
        .rdata0 (rd1),
        .rdata1 (rd2)
    );

    logic                       v2_reg;
    logic [PHASE_FRAC_BITS-1:0] r2_reg;
    logic signed [16:0]         c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (advance)
            v2_reg <= v1_reg && lk1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r2_reg <= r1;
            c2_reg <= cval;
        end
    end

    // stage 3: weighting products
    logic signed [SAMPLE_BITS-1:0] d1;
    logic signed [SAMPLE_BITS-1:0] d2;
    logic signed [33:0]            p1;
    logic signed [33:0]            p2;
    logic signed [16:0]            dsum;
    logic signed [16:0]            ddif;

    assign d1   = $signed(rd1);
    assign d2   = $signed(rd2);
    assign dsum = 17'(d1) + 17'(d2);
    assign ddif = 17'(d1) - 17'(d2);

    always_comb
    begin
        case (mode_reg)
            MODE_COSINE:
            begin
                p1 = 34'(ddif) * 34'(c2_reg);
                p2 = 34'(dsum) <<< COS_Q;
            end
            default:
            begin
                p1 = 34'(d1) * 34'($signed({1'b0, FULL - {1'b0, r2_reg}}));
                p2 = 34'(d2) * 34'($signed({1'b0, r2_reg}));
            end
        endcase
    end

    logic                          v3_reg;
    logic signed [33:0]            p1_3_reg;
    logic signed [33:0]            p2_3_reg;
    logic signed [SAMPLE_BITS-1:0] d1_3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (advance)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_3_reg <= p1;
            p2_3_reg <= p2;
            d1_3_reg <= d1;
        end
    end

    // stage 4: sum, floor shift, select
    logic signed [34:0]            sum4;
    logic signed [SAMPLE_BITS-1:0] res4;

    assign sum4 = 35'(p1_3_reg) + 35'(p2_3_reg);

    always_comb
    begin
        case (mode_reg)
            MODE_STEP:   res4 = d1_3_reg;
            MODE_LINEAR: res4 = SAMPLE_BITS'(sum4 >>> PHASE_FRAC_BITS);
            MODE_COSINE: res4 = SAMPLE_BITS'(sum4 >>> (COS_Q + 1));
            default:     res4 = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (advance)
            out_v_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= res4;
    end

    `WIU_ASSERT_NOW(a_size_range, clk, rst_n, 1'b1,
        (size_eff != '0) && (size_eff <= SIZE_W'(TABLE_DEPTH)), "size out of range")
    `WIU_ASSERT_NOW(a_index_in_range, clk, rst_n, v1_reg && lk1_reg,
        (i1 < size_eff) && (i2 < size_eff), "entry index beyond table size")
    `WIU_ASSERT_NEXT(a_stall_holds, clk, rst_n, !advance,
        $stable(v3_reg) && $stable(out_v_reg) && $stable(out_data_reg), "stall lost data")
    `WIU_ASSERT_NEXT(a_result_from_lookup, clk, rst_n, advance && !v3_reg,
        !out_v_reg, "result without lookup")

endmodule
`default_nettype wire

FILE: bench/wavetable_interpolator_unit_tb.sv
`default_nettype none
module wavetable_interpolator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wiu_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        logic        is_cfg;
        item_kind_t  kind;
        logic [9:0]  idx;
        logic [15:0] samp;
        logic [23:0] ph;
        logic        typed;
        logic [15:0] want;
        reg_index_t  cfg_reg;
        logic [10:0] val;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    wavetable_interpolator_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    logic signed [15:0] wave_mem [TABLE_DEPTH];
    int                 cos_quarter [COS_ENTRIES+1];
    interp_mode_t       cur_mode = MODE_LINEAR;
    logic [10:0]        cur_size = 11'd1024;
    logic [15:0]        pending_samples [$];
    int                 fail_count = 0;
    int                 idle_cycles = 0;
    int                 burst_left = 0;
    int                 cycle_no = 0;
    logic               in_rdy = 1'b0;
    logic               out_vld = 1'b0;
    logic [15:0]        out_dat = '0;
    stim_row_t          rows [$];

    function automatic void fill_cos_quarter();
        longint poly [6];
        longint u, u2, acc, v;
        poly = '{64'sd1324675879, 64'sd272375558, 64'sd22401994,
                 64'sd987048, 64'sd27060, 64'sd506};
        for (int k = 0; k <= COS_ENTRIES; k++)
        begin
            u = (longint'(k) * (longint'(1) << 30)) / COS_ENTRIES;
            u2 = (u * u) >>> 30;
            acc = poly[5];
            for (int j = 4; j >= 0; j--)
                acc = poly[j] - ((acc * u2) >>> 30);
            v = (longint'(1) << 30) - ((acc * u2) >>> 30);
            if (v < 0)
                v = 0;
            else
                v = (v * 32767 + (longint'(1) << 29)) >>> 30;
            if (v > 32767)
                v = 32767;
            cos_quarter[k] = int'(v);
        end
    endfunction

    function automatic logic [15:0] interpolate(logic [23:0] ph);
        longint span, a, r, i1, i2, d1, d2, c, res;
        span = (cur_size == 0) ? 1 : (cur_size > TABLE_DEPTH) ? TABLE_DEPTH : cur_size;
        a = longint'(ph) * span;
        r = a & 65535;
        i1 = (a >> 16) % span;
        i2 = (i1 + 1) % span;
        d1 = wave_mem[i1];
        d2 = wave_mem[i2];
        case (cur_mode)
            MODE_STEP:   res = d1;
            MODE_LINEAR: res = (d1 * (65536 - r) + d2 * r) >>> 16;
            MODE_COSINE:
            begin
                if (r < 32768)
                    c = cos_quarter[(r * COS_ENTRIES) >> 15];
                else
                    c = -cos_quarter[((65536 - r) * COS_ENTRIES) >> 15];
                res = ((d1 - d2) * c + (d1 + d2) * 32768) >>> 16;
            end
            default:     res = 0;
        endcase
        return res[15:0];
    endfunction

    always @(negedge clk)
    begin
        in_rdy  <= s_tready;
        out_vld <= m_tvalid;
        out_dat <= m_tdata;
    end

    // receiver: check results, stall on its own pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_no = cycle_no + 1;
            if (out_vld && m_tready)
            begin
                if (pending_samples.size() == 0)
                begin
                    $error("unexpected item sample_out=%0d", $signed(out_dat));
                    fail_count++;
                end
                else if (pending_samples[0] !== out_dat)
                begin
                    $error("sample_out expected %0d actual %0d",
                           $signed(pending_samples[0]), $signed(out_dat));
                    fail_count++;
                    void'(pending_samples.pop_front());
                end
                else
                    void'(pending_samples.pop_front());
            end
            if ((cycle_no % 400) < 120)
                m_tready <= 1'b1;
            else if ((cycle_no % 400) < 260)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= ($urandom_range(0, 2) == 0);
            if ((s_tvalid && in_rdy) || (out_vld && m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_item(item_kind_t kind, logic [9:0] idx, logic [15:0] samp,
                             logic [23:0] ph, logic typed, logic [15:0] want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, ph, samp, idx};
        @(posedge clk);
        while (!in_rdy)
            @(posedge clk);
        if (kind == ITEM_WRITE)
            wave_mem[idx] = samp;
        else
            pending_samples.push_back(typed ? want : interpolate(ph));
    endtask

    task automatic write_reg(reg_index_t which, logic [10:0] val);
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait (pending_samples.size() == 0);
        repeat (10) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {which, 2'b00};
        pwdata  <= {21'b0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == REG_INTERP_MODE)
            cur_mode = interp_mode_t'(val[1:0]);
        else
            cur_size = val;
    endtask

    function automatic void add_item(item_kind_t kind, logic [9:0] idx, logic [15:0] samp,
                                     logic [23:0] ph, logic typed, logic [15:0] want);
        rows.push_back('{1'b0, kind, idx, samp, ph, typed, want, REG_INTERP_MODE, 11'd0});
    endfunction

    function automatic void add_cfg(reg_index_t which, logic [10:0] val);
        rows.push_back('{1'b1, ITEM_WRITE, 10'd0, 16'd0, 24'd0, 1'b0, 16'd0, which, val});
    endfunction

    initial
    begin
        logic [10:0] sizes [10];
        logic [1:0]  modes [10];
        logic [15:0] samp;
        fill_cos_quarter();
        for (int i = 0; i < TABLE_DEPTH; i++)
            wave_mem[i] = '0;

        add_item(ITEM_WRITE, 10'd0, 16'h7FFF, 24'd0, 1'b0, 16'd0);
        add_item(ITEM_WRITE, 10'd1, 16'h8000, 24'd0, 1'b0, 16'd0);
        add_item(ITEM_WRITE, 10'd1023, 16'h0000, 24'd0, 1'b0, 16'd0);
        add_item(ITEM_WRITE, 10'd2, 16'hFFFF, 24'd0, 1'b0, 16'd0);
        add_item(ITEM_LOOKUP, 10'd0, 16'd0, 24'd0, 1'b1, 16'h7FFF);
        add_item(ITEM_LOOKUP, 10'h3FF, 16'hFFFF, 24'hFFFFFF, 1'b0, 16'd0);
        add_item(ITEM_LOOKUP, 10'd0, 16'd0, 24'h000020, 1'b0, 16'd0);
        add_cfg(REG_INTERP_MODE, 11'(MODE_STEP));
        add_item(ITEM_LOOKUP, 10'd0, 16'd0, 24'd0, 1'b1, 16'h7FFF);
        add_item(ITEM_LOOKUP, 10'd0, 16'd0, 24'h000040, 1'b1, 16'h8000);
        add_cfg(REG_INTERP_MODE, 11'(MODE_COSINE));
        add_item(ITEM_LOOKUP, 10'd0, 16'd0, 24'd0, 1'b0, 16'd0);
        add_item(ITEM_LOOKUP, 10'd0, 16'd0, 24'h000020, 1'b0, 16'd0);
        add_item(ITEM_LOOKUP, 10'd0, 16'd0, 24'h000030, 1'b0, 16'd0);
        add_item(ITEM_LOOKUP, 10'd0, 16'd0, 24'h00003F, 1'b0, 16'd0);
        add_cfg(REG_INTERP_MODE, 11'(MODE_ZERO));
        add_item(ITEM_LOOKUP, 10'd0, 16'd0, 24'h12000F, 1'b1, 16'd0);
        add_cfg(REG_INTERP_MODE, 11'(MODE_LINEAR));
        add_cfg(REG_TABLE_SIZE, 11'd1);
        add_item(ITEM_LOOKUP, 10'd0, 16'd0, 24'hFFFFFF, 1'b1, 16'h7FFF);
        add_cfg(REG_TABLE_SIZE, 11'd0);
        add_item(ITEM_LOOKUP, 10'd0, 16'd0, 24'hABCDEF, 1'b0, 16'd0);
        add_cfg(REG_TABLE_SIZE, 11'd2047);
        add_item(ITEM_LOOKUP, 10'd0, 16'd0, 24'h5A003F, 1'b0, 16'd0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[n])
        begin
            if (rows[n].is_cfg)
                write_reg(rows[n].cfg_reg, rows[n].val);
            else
                send_item(rows[n].kind, rows[n].idx, rows[n].samp, rows[n].ph,
                          rows[n].typed, rows[n].want);
        end

        // load every entry so that later lookups read written data only
        write_reg(REG_TABLE_SIZE, 11'd1024);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            case ($urandom_range(0, 7))
                0:       samp = 16'h7FFF;
                1:       samp = 16'h8000;
                default: samp = 16'($urandom);
            endcase
            send_item(ITEM_WRITE, i[9:0], samp, 24'($urandom), 1'b0, 16'd0);
        end

        sizes = '{11'd1024, 11'd1, 11'd1024, 11'd7, 11'd1000, 11'd2, 11'd0, 11'd2047,
                  11'd0, 11'd0};
        modes = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2};
        sizes[8] = 11'($urandom_range(1, 1024));
        sizes[9] = 11'($urandom_range(1, 64));
        for (int p = 0; p < 10; p++)
        begin
            write_reg(REG_INTERP_MODE, {9'd0, modes[p]});
            write_reg(REG_TABLE_SIZE, sizes[p]);
            for (int k = 0; k < 65; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    samp = ($urandom_range(0, 5) == 0) ? {$urandom_range(0, 1) ? 16'h7FFF
                                                                 : 16'h8000} : 16'($urandom);
                    send_item(ITEM_WRITE, 10'($urandom), samp, 24'($urandom), 1'b0, 16'd0);
                end
                else
                    send_item(ITEM_LOOKUP, 10'($urandom), 16'($urandom), 24'($urandom),
                              1'b0, 16'd0);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_samples.size() == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
